@@ rtl/cfd_pkg.sv @@
// Shared types and constants for the COBS frame decoder.
package cfd_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 13;
   localparam int KIND_W      = 2;
   localparam int MAX_PAYLOAD = 4096;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_DATA_W  = ((BYTE_W + LEN_W + 7) / 8) * 8;

   localparam logic [BYTE_W-1:0] FULL_CODE = 8'hFF;
   localparam logic [LEN_W-1:0]  CAP_LIMIT = LEN_W'(MAX_PAYLOAD);

   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_DATA     = 2'd0;
   localparam kind_type KIND_OK       = 2'd1;
   localparam kind_type KIND_TRUNC    = 2'd2;
   localparam kind_type KIND_OVERFLOW = 2'd3;

   typedef enum logic [1:0] {
      CLS_DELIM,
      CLS_CODE,
      CLS_DATA
   } item_class_type;

   // One classified word handed from the front end to the back end.
   typedef struct packed {
      item_class_type     cls;
      logic [BYTE_W-1:0]  value;      // payload byte for data words
      logic               trunc;      // delimiter arrived inside a block
      logic               zero_owed;  // code word must first emit a zero
   } entry_type;

endpackage

@@ rtl/cfd_front.sv @@
// Front end: accepts encoded bytes, tracks block position and classifies each word.
module cfd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] in_byte
   output logic                     push_valid,
   input  logic                     push_ready,
   output cfd_pkg::entry_type       push_entry
);
   import cfd_pkg::*;

   logic [BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic              zero_pending_ff, zero_pending_in;
   logic              accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   always_comb begin
      push_entry.value     = req_tdata;
      push_entry.trunc     = 1'b0;
      push_entry.zero_owed = 1'b0;
      bytes_left_in        = bytes_left_ff;
      zero_pending_in      = zero_pending_ff;
      if (req_tdata == '0) begin
         push_entry.cls   = CLS_DELIM;
         push_entry.trunc = (bytes_left_ff != '0);
         bytes_left_in    = '0;
         zero_pending_in  = 1'b0;
      end else if (bytes_left_ff == '0) begin
         push_entry.cls       = CLS_CODE;
         push_entry.zero_owed = zero_pending_ff;
         zero_pending_in      = (req_tdata != FULL_CODE);
         bytes_left_in        = req_tdata - BYTE_W'(1);
      end else begin
         push_entry.cls = CLS_DATA;
         bytes_left_in  = bytes_left_ff - BYTE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff   <= '0;
         zero_pending_ff <= 1'b0;
      end else if (accept) begin
         bytes_left_ff   <= bytes_left_in;
         zero_pending_ff <= zero_pending_in;
      end
   end

endmodule

@@ rtl/cfd_queue.sv @@
// Short queue of classified words between front and back end.
module cfd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  cfd_pkg::entry_type       push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output cfd_pkg::entry_type       pop_entry,
   output logic [cfd_pkg::QCNT_W-1:0] fill
);
   import cfd_pkg::*;

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign fill       = count_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/cfd_back.sv @@
// Back end: payload count, capacity check, fault tracking and result register.
module cfd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  cfd_pkg::entry_type              pop_entry,
   input  logic                            csr_wr_en,
   input  logic [cfd_pkg::LEN_W-1:0]       csr_wr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [cfd_pkg::KIND_W-1:0]      rsp_tuser,
   output logic                            rsp_tlast
);
   import cfd_pkg::*;

   logic [LEN_W-1:0]  max_len_ff;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              fault_ff, fault_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   kind_type          kind_ff, kind_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  cap;
   logic              take, wants_emit, at_cap;

   assign pop_ready  = !valid_ff || rsp_tready;
   assign take       = pop_valid && pop_ready;
   assign cap        = (max_len_ff > CAP_LIMIT) ? CAP_LIMIT : max_len_ff;
   assign at_cap     = (count_ff >= cap);
   assign wants_emit = (pop_entry.cls == CLS_DATA)
                    || (pop_entry.cls == CLS_CODE && pop_entry.zero_owed);

   always_comb begin
      count_in = count_ff;
      fault_in = fault_ff;
      valid_in = valid_ff && !rsp_tready;
      byte_in  = byte_ff;
      len_in   = len_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (take) begin
         if (pop_entry.cls == CLS_DELIM) begin
            valid_in = 1'b1;
            byte_in  = '0;
            len_in   = count_ff;
            last_in  = 1'b1;
            if (fault_ff) begin
               kind_in = KIND_OVERFLOW;
            end else if (pop_entry.trunc) begin
               kind_in = KIND_TRUNC;
            end else begin
               kind_in = KIND_OK;
            end
            count_in = '0;
            fault_in = 1'b0;
         end else if (!fault_ff && wants_emit) begin
            if (at_cap) begin
               fault_in = 1'b1;
            end else begin
               valid_in = 1'b1;
               // owed zero goes out in place of the code word
               byte_in  = (pop_entry.cls == CLS_DATA) ? pop_entry.value : '0;
               len_in   = '0;
               kind_in  = KIND_DATA;
               last_in  = 1'b0;
               count_in = count_ff + LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= CAP_LIMIT;
         count_ff   <= '0;
         fault_ff   <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         fault_ff <= fault_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      len_ff  <= len_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BYTE_W - LEN_W){1'b0}}, len_ff, byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/cobs_frame_decoder.sv @@
// Streaming COBS frame decoder top level.
// Usage:
//   req_* carries one received encoded byte per word; a zero byte ends a frame.
//   rsp_* carries decoded payload bytes (tuser = data) and one frame-end word
//   per frame with tlast high, tuser giving ok, truncated block or overflow
//   and the decoded length in tdata. csr_wr_en/csr_wr_data set the payload
//   capacity (values above 4096 act as 4096); write only while idle.
// Throughput: one byte per cycle sustained while rsp_tready stays high; the stages are the
//   front block tracker, two-entry queue, back-end counter and result reg.
// Path: an accepted byte is written into a queue slot and then into the result
//   register, which drives rsp_*.
// Reset: synchronous, active high; clears frame state, empties the queue,
//   drops any pending result and sets the capacity to 4096.
// Stall: when rsp_tready is low the result register holds, the back end stops
//   draining and the queue fills; req_tready falls once both queue entries
//   are taken. Code bytes and swallowed bytes also wait: the back end takes no
//   word while a result is held and rsp_tready is low.
module cobs_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] in_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] out_byte, [20:8] frame_len
   output logic [cfd_pkg::KIND_W-1:0]      rsp_tuser,   // [1:0] kind
   output logic                            rsp_tlast,   // frame_last
   input  logic                            csr_wr_en,
   input  logic [cfd_pkg::LEN_W-1:0]       csr_wr_data  // max_payload_len
);
   import cfd_pkg::*;

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   entry_type         push_entry, pop_entry;
   logic [QCNT_W-1:0] q_fill;

   cfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   cfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .fill       (q_fill)
   );

   cfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (pop_entry),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   // frame-end words carry a zero byte and a length within capacity limit
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_tdata[BYTE_W-1:0] == '0 && rsp_tdata[BYTE_W+LEN_W-1:BYTE_W] <= CAP_LIMIT)
      else $error("bad frame-end fields");

   // data words never close a frame and report no length
   a_data_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DATA |->
         !rsp_tlast && rsp_tdata[BYTE_W+LEN_W-1:BYTE_W] == '0)
      else $error("data word marked as frame end");

   // input is held off only when the queue is full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_fill == QCNT_W'(QUEUE_DEPTH))
      else $error("input stalled with queue space");

endmodule
